[hdl/bll_pkg.sv]
package bll_pkg;

  // Pool size and stored value width.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;

  // Fixed widths of the request and result fields.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned IN_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  // The free slot scan looks at SCAN_W slots per cycle.
  localparam int unsigned SCAN_W     = 8;
  localparam int unsigned POS_W      = $clog2(SCAN_W);
  localparam int unsigned NUM_CHUNKS = (CAPACITY + SCAN_W - 1) / SCAN_W;
  localparam int unsigned CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_AFTER = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_VALUE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_TAIL_WALK,
    S_DEL_HEAD,
    S_ALLOC,
    S_LINK_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic              free_en;
    logic [SLOT_W-1:0] free_slot;
  } alloc_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
  } alloc_rsp_t;

  typedef struct packed {
    logic              val_we;
    logic              link_we;
    logic [SLOT_W-1:0] addr;
    logic [DATA_W-1:0] val_data;
    logic [SLOT_W-1:0] link_data;
  } mem_wr_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } result_t;

  // Sign-extend or truncate a 32-bit request value to the stored width.
  function automatic logic [DATA_W-1:0] to_data(logic signed [IN_W-1:0] v);
    return DATA_W'(v);
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(logic [CNT_W-1:0] n);
    return COUNT_W'(n);
  endfunction

endpackage

[hdl/bll_ram.sv]
module bll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bll_alloc.sv]
module bll_alloc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bll_pkg::alloc_req_t req_i,
  output bll_pkg::alloc_rsp_t rsp_o
);

  logic [bll_pkg::CAPACITY-1:0] in_use_q, in_use_d;
  logic                         busy_q, busy_d;
  logic [bll_pkg::CHUNK_W-1:0]  chunk_q, chunk_d;

  logic [bll_pkg::SCAN_W-1:0] chunks [bll_pkg::NUM_CHUNKS];
  logic [bll_pkg::SCAN_W-1:0] cur_free;
  logic [bll_pkg::POS_W-1:0]  pos;
  logic                       hit;
  logic [bll_pkg::SLOT_W-1:0] slot;

  // Free map padded to whole chunks; padding slots count as taken.
  always_comb begin
    for (int c = 0; c < bll_pkg::NUM_CHUNKS; c++) begin
      for (int b = 0; b < bll_pkg::SCAN_W; b++) begin
        if (c * bll_pkg::SCAN_W + b < bll_pkg::CAPACITY) begin
          chunks[c][b] = !in_use_q[c * bll_pkg::SCAN_W + b];
        end else begin
          chunks[c][b] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cur_free = chunks[chunk_q];
    hit      = |cur_free;
    pos      = '0;
    for (int b = bll_pkg::SCAN_W - 1; b >= 0; b--) begin
      if (cur_free[b]) begin
        pos = bll_pkg::POS_W'(b);
      end
    end
    slot = bll_pkg::SLOT_W'({chunk_q, pos});
  end

  always_comb begin
    busy_d   = busy_q;
    chunk_d  = chunk_q;
    in_use_d = in_use_q;
    rsp_o    = '0;
    if (req_i.start) begin
      busy_d  = 1'b1;
      chunk_d = '0;
    end else if (busy_q) begin
      if (hit) begin
        busy_d     = 1'b0;
        rsp_o.done = 1'b1;
        rsp_o.slot = slot;
        in_use_d[slot] = 1'b1;
      end else begin
        chunk_d = chunk_q + 1'b1;
      end
    end
    if (req_i.free_en) begin
      in_use_d[req_i.free_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      busy_q   <= 1'b0;
      chunk_q  <= '0;
    end else begin
      in_use_q <= in_use_d;
      busy_q   <= busy_d;
      chunk_q  <= chunk_d;
    end
  end

endmodule

[hdl/bll_ctrl.sv]
module bll_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                stall_o,
  input  logic [bll_pkg::REQ_W-1:0]           req_type_i,
  input  logic signed [bll_pkg::IN_W-1:0]     item_value_i,
  input  logic signed [bll_pkg::IN_W-1:0]     search_key_i,
  input  logic                                out_free_i,
  output bll_pkg::result_t                    result_o,
  output bll_pkg::alloc_req_t                 alloc_req_o,
  input  bll_pkg::alloc_rsp_t                 alloc_rsp_i,
  output logic [bll_pkg::SLOT_W-1:0]          rd_addr_o,
  input  logic [bll_pkg::DATA_W-1:0]          val_rdata_i,
  input  logic [bll_pkg::SLOT_W-1:0]          link_rdata_i,
  output bll_pkg::mem_wr_t                    mem_wr_o
);

  bll_pkg::state_e state_q, state_d;

  logic [bll_pkg::REQ_W-1:0]    req_q, req_d;
  logic [bll_pkg::DATA_W-1:0]   item_q, item_d;
  logic [bll_pkg::DATA_W-1:0]   key_q, key_d;
  logic [bll_pkg::SLOT_W-1:0]   head_q, head_d;
  logic [bll_pkg::SLOT_W-1:0]   tail_q, tail_d;
  logic [bll_pkg::SLOT_W-1:0]   cur_q, cur_d;
  logic [bll_pkg::SLOT_W-1:0]   prev_q, prev_d;
  logic [bll_pkg::SLOT_W-1:0]   nxt_q, nxt_d;
  logic [bll_pkg::SLOT_W-1:0]   new_q, new_d;
  logic [bll_pkg::CNT_W-1:0]    idx_q, idx_d;
  logic [bll_pkg::CNT_W-1:0]    len_q, len_d;
  logic [bll_pkg::STATUS_W-1:0] status_q, status_d;

  logic                       full;
  logic                       len_one;
  logic [bll_pkg::DATA_W-1:0] target;
  logic                       match;

  assign full    = (len_q == bll_pkg::CNT_W'(bll_pkg::CAPACITY));
  assign len_one = (len_q == bll_pkg::CNT_W'(1));
  assign target  = (req_q == bll_pkg::REQ_INS_AFTER) ? key_q : item_q;
  // The one comparator shared by both searches.
  assign match   = (val_rdata_i == target);
  assign stall_o = (state_q != bll_pkg::S_IDLE);

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    item_d   = item_q;
    key_d    = key_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    nxt_d    = nxt_q;
    new_d    = new_q;
    idx_d    = idx_q;
    len_d    = len_q;
    status_d = status_q;

    rd_addr_o   = head_q;
    alloc_req_o = '0;
    alloc_req_o.free_slot = tail_q;
    mem_wr_o    = '0;
    mem_wr_o.val_data = item_q;
    mem_wr_o.addr     = alloc_rsp_i.slot;
    result_o    = '0;
    result_o.status = status_q;
    result_o.count  = bll_pkg::to_count(len_q);

    case (state_q)
      bll_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d    = req_type_i;
          item_d   = bll_pkg::to_data(item_value_i);
          key_d    = bll_pkg::to_data(search_key_i);
          status_d = bll_pkg::ST_OK;
          state_d  = bll_pkg::S_DECODE;
        end
      end

      bll_pkg::S_DECODE: begin
        // The head node is read here so that walks and delete first can start.
        cur_d  = head_q;
        prev_d = head_q;
        idx_d  = '0;
        case (req_q)
          bll_pkg::REQ_INS_FRONT, bll_pkg::REQ_INS_BACK: begin
            if (full) begin
              status_d = bll_pkg::ST_FULL;
              state_d  = bll_pkg::S_DONE;
            end else begin
              alloc_req_o.start = 1'b1;
              state_d = bll_pkg::S_ALLOC;
            end
          end
          bll_pkg::REQ_INS_AFTER, bll_pkg::REQ_DEL_VALUE: begin
            if (len_q == '0) begin
              status_d = bll_pkg::ST_EMPTY;
              state_d  = bll_pkg::S_DONE;
            end else begin
              state_d = bll_pkg::S_FIND;
            end
          end
          bll_pkg::REQ_DEL_FIRST: begin
            if (len_q == '0) begin
              status_d = bll_pkg::ST_EMPTY;
              state_d  = bll_pkg::S_DONE;
            end else begin
              alloc_req_o.free_en   = 1'b1;
              alloc_req_o.free_slot = head_q;
              state_d = bll_pkg::S_DEL_HEAD;
            end
          end
          bll_pkg::REQ_DEL_LAST: begin
            if (len_q == '0) begin
              status_d = bll_pkg::ST_EMPTY;
              state_d  = bll_pkg::S_DONE;
            end else begin
              alloc_req_o.free_en   = 1'b1;
              alloc_req_o.free_slot = tail_q;
              if (len_one) begin
                head_d  = '0;
                tail_d  = '0;
                len_d   = len_q - 1'b1;
                state_d = bll_pkg::S_DONE;
              end else begin
                state_d = bll_pkg::S_TAIL_WALK;
              end
            end
          end
          default: begin
            state_d = bll_pkg::S_DONE;
          end
        endcase
      end

      bll_pkg::S_FIND: begin
        if (match) begin
          if (req_q == bll_pkg::REQ_INS_AFTER) begin
            nxt_d = link_rdata_i;
            if (full) begin
              status_d = bll_pkg::ST_FULL;
              state_d  = bll_pkg::S_DONE;
            end else begin
              alloc_req_o.start = 1'b1;
              state_d = bll_pkg::S_ALLOC;
            end
          end else begin
            alloc_req_o.free_en   = 1'b1;
            alloc_req_o.free_slot = cur_q;
            if (cur_q == head_q) begin
              if (len_one) begin
                head_d = '0;
                tail_d = '0;
              end else begin
                head_d = link_rdata_i;
              end
            end else begin
              // Unlink the node from its predecessor.
              mem_wr_o.link_we   = 1'b1;
              mem_wr_o.addr      = prev_q;
              mem_wr_o.link_data = link_rdata_i;
              if (cur_q == tail_q) begin
                tail_d = prev_q;
              end
            end
            len_d   = len_q - 1'b1;
            state_d = bll_pkg::S_DONE;
          end
        end else if (idx_q + 1'b1 == len_q) begin
          status_d = bll_pkg::ST_NOTFOUND;
          state_d  = bll_pkg::S_DONE;
        end else begin
          prev_d    = cur_q;
          cur_d     = link_rdata_i;
          idx_d     = idx_q + 1'b1;
          rd_addr_o = link_rdata_i;
        end
      end

      bll_pkg::S_TAIL_WALK: begin
        if (idx_q + bll_pkg::CNT_W'(2) == len_q) begin
          tail_d  = cur_q;
          len_d   = len_q - 1'b1;
          state_d = bll_pkg::S_DONE;
        end else begin
          cur_d     = link_rdata_i;
          idx_d     = idx_q + 1'b1;
          rd_addr_o = link_rdata_i;
        end
      end

      bll_pkg::S_DEL_HEAD: begin
        len_d = len_q - 1'b1;
        if (len_one) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = link_rdata_i;
        end
        state_d = bll_pkg::S_DONE;
      end

      bll_pkg::S_ALLOC: begin
        if (alloc_rsp_i.done) begin
          new_d            = alloc_rsp_i.slot;
          mem_wr_o.val_we  = 1'b1;
          mem_wr_o.link_we = 1'b1;
          case (req_q)
            bll_pkg::REQ_INS_FRONT: begin
              mem_wr_o.link_data = (len_q == '0) ? '0 : head_q;
              head_d = alloc_rsp_i.slot;
              if (len_q == '0) begin
                tail_d = alloc_rsp_i.slot;
              end
              len_d   = len_q + 1'b1;
              state_d = bll_pkg::S_DONE;
            end
            bll_pkg::REQ_INS_BACK: begin
              mem_wr_o.link_data = '0;
              if (len_q == '0) begin
                head_d  = alloc_rsp_i.slot;
                tail_d  = alloc_rsp_i.slot;
                len_d   = len_q + 1'b1;
                state_d = bll_pkg::S_DONE;
              end else begin
                state_d = bll_pkg::S_LINK_WR;
              end
            end
            default: begin
              mem_wr_o.link_data = nxt_q;
              state_d = bll_pkg::S_LINK_WR;
            end
          endcase
        end
      end

      bll_pkg::S_LINK_WR: begin
        // Point the old tail, or the found node, at the new node.
        mem_wr_o.link_we   = 1'b1;
        mem_wr_o.link_data = new_q;
        mem_wr_o.addr      = (req_q == bll_pkg::REQ_INS_BACK) ? tail_q : cur_q;
        if (req_q == bll_pkg::REQ_INS_BACK || cur_q == tail_q) begin
          tail_d = new_q;
        end
        len_d   = len_q + 1'b1;
        state_d = bll_pkg::S_DONE;
      end

      bll_pkg::S_DONE: begin
        if (out_free_i) begin
          result_o.valid = 1'b1;
          state_d = bll_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bll_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bll_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    item_q   <= item_d;
    key_q    <= key_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    nxt_q    <= nxt_d;
    new_q    <= new_d;
    idx_q    <= idx_d;
    status_q <= status_d;
  end

endmodule

[hdl/bounded_linked_list_engine.sv]
// Bounded singly linked list of signed values held in a pool of CAPACITY node slots
// (64 here), with head and tail pointers and a node count. Each input beat is one
// request: insert at the front, insert at the back, insert after the first node equal
// to search_key, delete the first node, delete the last node, or delete the first node
// equal to item_value; each request returns one output beat with a status (ok, list
// empty, not found, pool full) and the node count after the request. Requests are
// handled one at a time, and in_stall_o stays high from the cycle after a beat is taken
// until its result has been moved into the output register, which lets the next
// request come in while a result still waits downstream. A request passes through its
// acceptance, decode and the result hand-off, plus its list walk, its free slot scan,
// and one more step for a delete first or for the link write of an insert after a key
// or at the back of a non-empty list. The walk reads one node per cycle from the node
// value and link RAMs, so a search visits up to as many nodes as the list holds and
// delete last walks length minus one nodes. A new node takes the lowest free slot,
// found by scanning the slot map eight slots per cycle. The slowest request is an
// insert after the last node of a list one short of full whose only free slot sits in
// the last group of eight. Node storage needs no clearing after reset: the slot map,
// the head and tail pointers and the node count are reset instead.
module bounded_linked_list_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bll_pkg::REQ_W-1:0]            req_type_i,
  input  logic signed [bll_pkg::IN_W-1:0]      item_value_i,
  input  logic signed [bll_pkg::IN_W-1:0]      search_key_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [bll_pkg::STATUS_W-1:0]         status_o,
  output logic [bll_pkg::COUNT_W-1:0]          node_count_o
);

  bll_pkg::result_t    result;
  bll_pkg::alloc_req_t alloc_req;
  bll_pkg::alloc_rsp_t alloc_rsp;
  bll_pkg::mem_wr_t    mem_wr;

  logic [bll_pkg::SLOT_W-1:0] rd_addr;
  logic [bll_pkg::DATA_W-1:0] val_rdata;
  logic [bll_pkg::SLOT_W-1:0] link_rdata;

  logic                          out_valid_q, out_valid_d;
  logic [bll_pkg::STATUS_W-1:0]  status_q;
  logic [bll_pkg::COUNT_W-1:0]   count_q;
  logic                          out_free;

  // The sequencer: decodes the request, walks the list and updates the pointers.
  bll_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .stall_o      (in_stall_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .search_key_i (search_key_i),
    .out_free_i   (out_free),
    .result_o     (result),
    .alloc_req_o  (alloc_req),
    .alloc_rsp_i  (alloc_rsp),
    .rd_addr_o    (rd_addr),
    .val_rdata_i  (val_rdata),
    .link_rdata_i (link_rdata),
    .mem_wr_o     (mem_wr)
  );

  // Slot map with the lowest free slot scan.
  bll_alloc u_alloc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alloc_req),
    .rsp_o  (alloc_rsp)
  );

  // Node values and next links share the read address, so a walk step sees both.
  bll_ram #(
    .WIDTH (bll_pkg::DATA_W),
    .DEPTH (bll_pkg::CAPACITY)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.val_we),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.val_data),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  bll_ram #(
    .WIDTH (bll_pkg::SLOT_W),
    .DEPTH (bll_pkg::CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.link_we),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.link_data),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  // Output register. A new result may enter when the register is empty or its
  // beat is taken in the same cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (result.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      status_q <= result.status;
      count_q  <= result.count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign node_count_o = count_q;

endmodule
